FILE: hdl/base64_stream_encoder_unit_defines.svh
// Assertion macros shared by the Base64 stream encoder RTL.
`ifndef BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_ENCODER_UNIT_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define B64SE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define B64SE_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

FILE: hdl/b64se_pkg.sv
// Package with register map codes and the Base64 symbol table for the encoder.
package b64se_pkg;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [2:0] REG_URL_ALPHABET = 3'd0;
  localparam logic [2:0] REG_PAD_ENABLE   = 3'd1;
  localparam logic [2:0] REG_LINE_MAX     = 3'd2;
  localparam logic [2:0] REG_SEP_LEN      = 3'd3;
  localparam logic [2:0] REG_SEP_FIRST    = 3'd4;
  localparam logic [2:0] REG_SEP_SECOND   = 3'd5;

  // Widths and fixed values.
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned BurstDepth = 6;
  localparam logic [7:0]  PAD_CHAR   = 8'h3d;

  typedef logic [7:0] char_t;
  typedef logic [2:0] burst_cnt_t;

  // Maps a 6-bit value onto the standard or URL-safe alphabet.
  function automatic char_t sym(input logic [5:0] v, input logic url);
    char_t c;
    c = 8'h00;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v - 6'd26};
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v - 6'd52};
      6'd62:         c = url ? 8'h2d : 8'h2b;
      default:       c = url ? 8'h5f : 8'h2f;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/base64_stream_encoder_unit.sv
// Streaming Base64 encoder with configurable alphabet, padding and line breaks.
//
// Usage: source bytes arrive on the slave stream (s_tdata, s_tlast marks the
// final byte of a message). Encoded characters and separator bytes leave on
// the master stream; m_tlast marks the final character of a message and is
// never set on a separator byte. Registers are written over the APB port; the
// user must do so only while the block is idle, as the block does not enforce it.
// The first character caused by a byte passes from the burst buffer into the
// output register, from which the receiver takes it.
// Throughput: one output character per cycle while m_tready is high. A byte
// is taken only while the burst buffer is empty or its last entry moves out
// in the same cycle. The two bytes after a full group follow back to back,
// but the byte after a group waits until its characters and any separator
// bytes have drained.
// Reset: configuration returns to standard alphabet, padding on, no line
// breaks, CR LF separator; the partial group and line position are cleared.
// Stall: with m_tready low the output register holds its character; the burst
// buffer keeps its entries, and s_tready stays low while any remain.
module base64_stream_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // Source stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  // Encoded stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  output logic        m_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [b64se_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "base64_stream_encoder_unit_defines.svh"

  // Configuration registers.
  logic        url_alphabet;
  logic        pad_enable;
  logic [11:0] line_max;
  logic [1:0]  sep_len;
  logic [7:0]  sep_first;
  logic [7:0]  sep_second;

  // Encoder state.
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  logic [11:0] line_position;
  logic [15:0] held_bytes_next;
  logic [1:0]  held_count_next;
  logic [11:0] line_position_next;

  // Burst buffer and output register.
  b64se_pkg::char_t     burst_char [b64se_pkg::BurstDepth];
  logic                 burst_last [b64se_pkg::BurstDepth];
  b64se_pkg::burst_cnt_t burst_count;
  b64se_pkg::char_t     fill_char [b64se_pkg::BurstDepth];
  logic                 fill_last [b64se_pkg::BurstDepth];
  b64se_pkg::burst_cnt_t fill_count;
  logic                 out_valid;
  b64se_pkg::char_t     out_char;
  logic                 out_last;

  logic       cfg_write;
  logic       accept;
  logic       load;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[b64se_pkg::AddrWidth-1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
      pad_enable   <= 1'b1;
      line_max     <= 12'd0;
      sep_len      <= 2'd2;
      sep_first    <= 8'd13;
      sep_second   <= 8'd10;
    end else if (cfg_write) begin
      case (reg_index)
        b64se_pkg::REG_URL_ALPHABET: url_alphabet <= pwdata[0];
        b64se_pkg::REG_PAD_ENABLE:   pad_enable   <= pwdata[0];
        b64se_pkg::REG_LINE_MAX:     line_max     <= pwdata[11:0];
        b64se_pkg::REG_SEP_LEN:      sep_len      <= pwdata[1:0];
        b64se_pkg::REG_SEP_FIRST:    sep_first    <= pwdata[7:0];
        b64se_pkg::REG_SEP_SECOND:   sep_second   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_index)
      b64se_pkg::REG_URL_ALPHABET: prdata = {31'd0, url_alphabet};
      b64se_pkg::REG_PAD_ENABLE:   prdata = {31'd0, pad_enable};
      b64se_pkg::REG_LINE_MAX:     prdata = {20'd0, line_max};
      b64se_pkg::REG_SEP_LEN:      prdata = {30'd0, sep_len};
      b64se_pkg::REG_SEP_FIRST:    prdata = {24'd0, sep_first};
      b64se_pkg::REG_SEP_SECOND:   prdata = {24'd0, sep_second};
      default:                     prdata = 32'd0;
    endcase
  end

  // Handshake: the buffer takes a new burst once it is empty or its last
  // entry moves to the output register in this cycle.
  assign load     = (burst_count != 3'd0) && (!out_valid || m_tready);
  assign s_tready = (burst_count == 3'd0) || ((burst_count == 3'd1) && load);
  assign accept   = s_tvalid && s_tready;

  // Burst for one source byte and the next encoder state.
  always_comb begin
    logic [23:0] bits;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        lines_on;
    logic [11:0] lmax;
    logic [11:0] pos4;
    logic [1:0]  sep_count;
    for (int i = 0; i < b64se_pkg::BurstDepth; i++) begin
      fill_char[i] = b64se_pkg::PAD_CHAR;
      fill_last[i] = 1'b0;
    end
    fill_count         = 3'd0;
    held_bytes_next    = held_bytes;
    held_count_next    = held_count;
    line_position_next = line_position;
    bits      = {held_bytes, s_tdata};
    lmax      = {line_max[11:2], 2'b00};
    lines_on  = (line_max[11:2] != 10'd0);
    pos4      = line_position + 12'd4;
    sep_count = (sep_len == 2'd3) ? 2'd2 : sep_len;
    b0        = (held_count == 2'd0) ? s_tdata : held_bytes[15:8];
    b1        = s_tdata;

    if (held_count[1]) begin
      // Full group of three bytes gives four characters, plus the separator at a line end.
      fill_char[0] = b64se_pkg::sym(bits[23:18], url_alphabet);
      fill_char[1] = b64se_pkg::sym(bits[17:12], url_alphabet);
      fill_char[2] = b64se_pkg::sym(bits[11:6], url_alphabet);
      fill_char[3] = b64se_pkg::sym(bits[5:0], url_alphabet);
      fill_last[3] = s_tlast;
      fill_count   = 3'd4;
      held_bytes_next = 16'd0;
      held_count_next = 2'd0;
      if (lines_on) begin
        line_position_next = pos4;
        if (pos4 >= lmax) begin
          line_position_next = 12'd0;
          if (!s_tlast) begin
            fill_char[4] = sep_first;
            fill_char[5] = sep_second;
            fill_count   = 3'd4 + {1'b0, sep_count};
          end
        end
      end
    end else if (s_tlast && (held_count == 2'd0)) begin
      // Single final byte: two characters and, with padding on, two pad characters.
      fill_char[0] = b64se_pkg::sym(b0[7:2], url_alphabet);
      fill_char[1] = b64se_pkg::sym({b0[1:0], 4'b0000}, url_alphabet);
      fill_last[1] = !pad_enable;
      fill_last[3] = 1'b1;
      fill_count   = pad_enable ? 3'd4 : 3'd2;
    end else if (s_tlast) begin
      // Two final bytes: three characters and, with padding on, one pad character.
      fill_char[0] = b64se_pkg::sym(b0[7:2], url_alphabet);
      fill_char[1] = b64se_pkg::sym({b0[1:0], b1[7:4]}, url_alphabet);
      fill_char[2] = b64se_pkg::sym({b1[3:0], 2'b00}, url_alphabet);
      fill_last[2] = !pad_enable;
      fill_last[3] = 1'b1;
      fill_count   = pad_enable ? 3'd4 : 3'd3;
    end else if (held_count == 2'd1) begin
      held_bytes_next = {held_bytes[15:8], s_tdata};
      held_count_next = 2'd2;
    end else begin
      held_bytes_next = {s_tdata, 8'h00};
      held_count_next = 2'd1;
    end

    // End of message clears the group and the line.
    if (s_tlast) begin
      held_bytes_next    = 16'd0;
      held_count_next    = 2'd0;
      line_position_next = 12'd0;
    end
  end

  // Encoder state and buffer fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes    <= 16'd0;
      held_count    <= 2'd0;
      line_position <= 12'd0;
      burst_count   <= 3'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        held_bytes    <= held_bytes_next;
        held_count    <= held_count_next;
        line_position <= line_position_next;
        burst_count   <= fill_count;
      end else if (load) begin
        burst_count <= burst_count - 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Buffer entries shift toward the output; a new burst replaces them.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < b64se_pkg::BurstDepth; i++) begin
        burst_char[i] <= fill_char[i];
        burst_last[i] <= fill_last[i];
      end
    end else if (load) begin
      for (int i = 0; i < b64se_pkg::BurstDepth - 1; i++) begin
        burst_char[i] <= burst_char[i+1];
        burst_last[i] <= burst_last[i+1];
      end
    end
    if (load) begin
      out_char <= burst_char[0];
      out_last <= burst_last[0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

  // Checks on the buffer and the encoder state.
  `B64SE_ASSERT_ALWAYS(a_burst_bound, burst_count <= 3'd6, "burst buffer overfilled")
  `B64SE_ASSERT_ALWAYS(a_held_bound, held_count != 2'd3, "held byte count out of range")
  `B64SE_ASSERT_ALWAYS(a_line_aligned, line_position[1:0] == 2'b00, "line position not aligned")
  `B64SE_ASSERT_NEXT(a_msg_end, accept && s_tlast, {held_count, line_position} == 14'd0, "end not cleared")
  `B64SE_ASSERT_NEXT(a_out_fill, (burst_count != 3'd0) && !out_valid, out_valid, "output not filled")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the Base64 stream encoder with driver, monitor and register writer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct   = 29;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned PhaseBytes = 72;

  // One source byte as offered on the slave stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_byte_t;

  // One encoded character as expected on the master stream.
  typedef struct packed {
    b64se_pkg::char_t ch;
    logic  last;
  } enc_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [b64se_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and expectation stores.
  src_byte_t   byte_q[$];
  enc_char_t   enc_q[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned chars_checked = 0;
  int unsigned messages = 0;
  int unsigned settings = 1;
  int unsigned errors = 0;
  logic        src_fire = 1'b0;
  logic        no_idle = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  // Mirror of the configuration registers, starting at their reset values.
  logic        cfg_url = 1'b0;
  logic        cfg_pad = 1'b1;
  logic [11:0] cfg_line = 12'd0;
  logic [1:0]  cfg_sep_len = 2'd2;
  logic [7:0]  cfg_sep1 = 8'd13;
  logic [7:0]  cfg_sep2 = 8'd10;

  // Mirror of the partial group and line position.
  logic [15:0] grp_bytes = 16'h0;
  logic [1:0]  grp_count = 2'd0;
  logic [11:0] line_pos = 12'd0;

  base64_stream_encoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Translates a 6-bit value into a character of the selected alphabet.
  function automatic b64se_pkg::char_t b64_symbol(input logic [5:0] v);
    if (v < 6'd26) return 8'd65 + 8'(v);
    if (v < 6'd52) return 8'd97 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'd48 + 8'(v - 6'd52);
    if (v == 6'd62) return cfg_url ? "-" : "+";
    return cfg_url ? "_" : "/";
  endfunction

  function automatic void expect_char(input b64se_pkg::char_t ch, input logic last);
    enc_char_t e;
    e.ch = ch;
    e.last = last;
    enc_q.push_back(e);
  endfunction

  // Works out the characters that one accepted source byte causes.
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] bits;
    logic [11:0] lmax;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [1:0]  nsep;
    lmax = cfg_line & 12'hffc;
    if (grp_count == 2'd2) begin
      bits = {grp_bytes, b};
      expect_char(b64_symbol(bits[23:18]), 1'b0);
      expect_char(b64_symbol(bits[17:12]), 1'b0);
      expect_char(b64_symbol(bits[11:6]), 1'b0);
      expect_char(b64_symbol(bits[5:0]), last);
      grp_count = 2'd0;
      grp_bytes = 16'h0;
      if (lmax >= 12'd4) begin
        line_pos = line_pos + 12'd4;
        if (line_pos >= lmax) begin
          line_pos = 12'd0;
          // A separator only goes out when more of the message follows.
          if (!last) begin
            nsep = (cfg_sep_len == 2'd3) ? 2'd2 : cfg_sep_len;
            if (nsep >= 2'd1) expect_char(cfg_sep1, 1'b0);
            if (nsep >= 2'd2) expect_char(cfg_sep2, 1'b0);
          end
        end
      end
    end else if (grp_count == 2'd1) begin
      grp_bytes[7:0] = b;
      grp_count = 2'd2;
    end else begin
      grp_bytes = {b, 8'h00};
      grp_count = 2'd1;
    end

    // Flush of a partial final group, with optional padding.
    if (last && grp_count != 2'd0) begin
      b0 = grp_bytes[15:8];
      b1 = grp_bytes[7:0];
      expect_char(b64_symbol(b0[7:2]), 1'b0);
      if (grp_count == 2'd1) begin
        expect_char(b64_symbol({b0[1:0], 4'b0000}), !cfg_pad);
        if (cfg_pad) begin
          expect_char(b64se_pkg::PAD_CHAR, 1'b0);
          expect_char(b64se_pkg::PAD_CHAR, 1'b1);
        end
      end else begin
        expect_char(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
        expect_char(b64_symbol({b1[3:0], 2'b00}), !cfg_pad);
        if (cfg_pad) expect_char(b64se_pkg::PAD_CHAR, 1'b1);
      end
    end
    if (last) begin
      grp_bytes = 16'h0;
      grp_count = 2'd0;
      line_pos = 12'd0;
    end
  endfunction

  // Source driver: offers the next pending byte once the current one is taken.
  always @(negedge clk) begin
    src_byte_t nxt;
    if (!rst && (!s_tvalid || src_fire)) begin
      if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
        nxt = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.data;
        s_tlast <= nxt.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 60) begin
      m_tready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: predicts on each source transaction and checks each output one.
  always @(posedge clk) begin
    enc_char_t e;
    if (rst) begin
      src_fire <= 1'b0;
    end else begin
      src_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        chars_checked <= chars_checked + 1;
        if (enc_q.size() == 0) begin
          $error("character 0x%02h arrived with nothing expected", m_tdata);
          errors++;
        end else begin
          e = enc_q.pop_front();
          if (m_tdata !== e.ch) begin
            $error("out_char mismatch: expected 0x%02h, actual 0x%02h", e.ch, m_tdata);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $error("no transaction for %0d cycles", quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    src_byte_t it;
    it.data = b;
    it.last = last;
    byte_q.push_back(it);
    bytes_queued++;
    if (last) messages++;
  endtask

  // Queues random messages, short and long ones about equally often, until the phase is filled.
  task automatic queue_messages(input int unsigned total);
    int unsigned left;
    int unsigned len;
    left = total;
    while (left != 0) begin
      len = ($urandom_range(1) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
      if (len > left) len = left;
      for (int unsigned i = 0; i < len; i++) push_byte(8'($urandom_range(255)), i == len - 1);
      left -= len;
    end
  endtask

  // Waits until every queued byte is taken and every character has arrived.
  task automatic drain();
    do @(posedge clk); while (bytes_taken != bytes_queued || enc_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic url, input logic pad, input logic [11:0] line,
                            input logic [1:0] sep_len, input logic [7:0] sep1,
                            input logic [7:0] sep2);
    write_reg(b64se_pkg::REG_URL_ALPHABET, {31'h0, url});
    write_reg(b64se_pkg::REG_PAD_ENABLE, {31'h0, pad});
    write_reg(b64se_pkg::REG_LINE_MAX, {20'h0, line});
    write_reg(b64se_pkg::REG_SEP_LEN, {30'h0, sep_len});
    write_reg(b64se_pkg::REG_SEP_FIRST, {24'h0, sep1});
    write_reg(b64se_pkg::REG_SEP_SECOND, {24'h0, sep2});
    cfg_url = url;
    cfg_pad = pad;
    cfg_line = line;
    cfg_sep_len = sep_len;
    cfg_sep1 = sep1;
    cfg_sep2 = sep2;
    settings++;
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one- and two-byte tails with padding, all-zero and
    // all-one groups, and groups that hit both top symbols.
    push_byte("f", 1'b1);
    push_byte("f", 1'b0);
    push_byte("o", 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hfb, 1'b0);
    push_byte(8'hef, 1'b0);
    push_byte(8'hbe, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    drain();

    // URL alphabet, no padding, line length rounded down to eight, and an
    // oversized separator length. First a message ending on a full line,
    // then one whose partial tail follows a full line.
    set_config(1'b1, 1'b0, 12'd9, 2'd3, 8'h2a, 8'h7e);
    push_byte(8'hfb, 1'b0);
    push_byte(8'hef, 1'b0);
    push_byte(8'hbe, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h4d, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6e, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h80, 1'b1);
    drain();

    // Shortest lines with a one-byte separator; the long hold-off falls here.
    set_config(1'b0, 1'b1, 12'd4, 2'd1, 8'($urandom_range(255)), 8'($urandom_range(255)));
    queue_messages(PhaseBytes);
    drain();

    // Longest line setting and no separator.
    set_config(1'b1, 1'b1, 12'd4095, 2'd0, 8'hff, 8'h00);
    queue_messages(PhaseBytes);
    drain();

    // Line length below four: no breaks; both sides run without stalls.
    no_idle = 1'b1;
    set_config(1'b0, 1'b0, 12'd3, 2'd2, 8'h00, 8'hff);
    queue_messages(PhaseBytes);
    drain();
    no_idle = 1'b0;

    // Common MIME-like setting.
    set_config(1'b1, 1'b0, 12'd76, 2'd2, 8'd13, 8'd10);
    queue_messages(PhaseBytes);
    drain();

    // Short lines with the oversized separator length.
    set_config(1'b0, 1'b1, 12'd12, 2'd3, 8'h00, 8'hff);
    queue_messages(PhaseBytes);
    drain();

    // Random settings.
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 12'($urandom_range(4, 40)),
               2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    queue_messages(PhaseBytes);
    drain();

    $display("Run covered %0d source bytes in %0d messages under %0d register settings.",
             bytes_taken, messages, settings);
    $display("%0d encoded characters compared, including a long receiver hold-off.",
             chars_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
